[sv/tdsq_pkg.sv]
package tdsq_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ACK   = 2'd1,
    ACT_CHAIN = 2'd2
  } action_t;

  // player steps happen on tick counts that are multiples of this
  localparam int STEP_PERIOD = 10;
  // chain request every 2**CHAIN_BITS ticks
  localparam int CHAIN_BITS  = 5;

  localparam logic [15:0] STOP_MARKER_RESET = 16'hFFFF;

  typedef struct packed {
    logic [15:0] duration;
    logic [15:0] divisor;
  } note_t;

  typedef struct packed {
    logic [31:0] tick_count;
    logic        speaker_on;
    logic [15:0] tone_divisor;
    logic        playing;
    action_t     interrupt_action;
  } result_t;

  typedef struct packed {
    logic gate;
    logic active;
  } player_status_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

[sv/tdsq_note_mem.sv]
module tdsq_note_mem import tdsq_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  note_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output note_t         rd_data
);

  note_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds between fetches
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/tdsq_player.sv]
module tdsq_player import tdsq_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [1:0]     op,
  input  logic [7:0]     note_address,
  input  logic [15:0]    note_duration,
  input  logic [15:0]    note_divisor,
  input  logic [15:0]    stop_marker,
  input  note_t          rd_data,
  output logic           wr_en,
  output logic [AW-1:0]  wr_addr,
  output note_t          wr_data,
  output logic           rd_en,
  output logic [AW-1:0]  rd_addr,
  output result_t        result,
  output player_status_t status
);

  localparam int          EW       = (AW > 8) ? AW : 8;
  localparam int          RS       = 8 + AW;
  localparam logic [9:0]  RECIP    = 10'(((64'd1 << RS) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));
  localparam logic [3:0]  RES_LAST = 4'(STEP_PERIOD - 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

  logic [31:0]   tick_counter, tick_counter_next;
  logic [3:0]    residue, residue_next;
  logic [AW-1:0] note_pointer, note_pointer_next;
  logic [15:0]   steps_remaining, steps_remaining_next;
  logic          player_active, player_active_next;
  logic          gate_enabled, gate_enabled_next;
  logic [15:0]   current_divisor, current_divisor_next;
  logic          fwd_valid, fwd_valid_next;
  note_t         fwd_word, fwd_word_next;

  logic [17:0]   addr_prod;
  logic [7:0]    addr_quo;
  logic [7:0]    addr_rem;
  logic [EW-1:0] addr_ext;
  logic [AW-1:0] addr_red;
  logic [AW-1:0] ptr_inc;
  note_t         note_word;
  action_t       action;

  // address modulo depth: quotient by reciprocal multiply, exact for 8-bit addresses
  assign addr_prod = note_address * RECIP;
  assign addr_quo  = 8'(addr_prod >> RS);
  assign addr_rem  = note_address - 8'(addr_quo * 8'(DEPTH));

  assign addr_ext  = EW'(addr_rem);
  assign addr_red  = addr_ext[AW-1:0];
  assign ptr_inc   = (note_pointer == PTR_LAST) ? '0 : note_pointer + 1'b1;
  // entry under the pointer: last fetch, or a later write to that entry
  assign note_word = fwd_valid ? fwd_word : rd_data;

  always_comb begin
    tick_counter_next    = tick_counter;
    residue_next         = residue;
    note_pointer_next    = note_pointer;
    steps_remaining_next = steps_remaining;
    player_active_next   = player_active;
    gate_enabled_next    = gate_enabled;
    current_divisor_next = current_divisor;
    action               = ACT_NONE;
    wr_en                = 1'b0;
    rd_en                = 1'b0;
    wr_addr              = addr_red;
    wr_data              = '{duration: note_duration, divisor: note_divisor};
    if (accept) begin
      case (op)
        OP_TICK: begin
          tick_counter_next = tick_counter + 32'd1;
          // true count wraps to zero, which is a multiple of the period
          if (tick_counter == '1 || residue == RES_LAST) begin
            residue_next = '0;
          end else begin
            residue_next = residue + 4'd1;
          end
          if (residue_next == '0 && player_active) begin
            if (steps_remaining != '0) begin
              steps_remaining_next = steps_remaining - 16'd1;
            end else if (note_word.duration == stop_marker) begin
              player_active_next = 1'b0;
              gate_enabled_next  = 1'b0;
            end else begin
              steps_remaining_next = note_word.duration - 16'd1;
              if (note_word.divisor == '0) begin
                gate_enabled_next = 1'b0;
              end else begin
                current_divisor_next = note_word.divisor;
                gate_enabled_next    = 1'b1;
              end
              note_pointer_next = ptr_inc;
              rd_en             = 1'b1;
            end
          end
          action = (tick_counter_next[CHAIN_BITS-1:0] == '0) ? ACT_CHAIN : ACT_ACK;
        end
        OP_WRITE: begin
          wr_en = 1'b1;
        end
        OP_START: begin
          note_pointer_next    = addr_red;
          steps_remaining_next = '0;
          player_active_next   = 1'b1;
          rd_en                = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_addr = note_pointer_next;

  always_comb begin
    fwd_valid_next = fwd_valid;
    fwd_word_next  = fwd_word;
    if (wr_en && addr_red == note_pointer) begin
      fwd_valid_next = 1'b1;
      fwd_word_next  = wr_data;
    end else if (rd_en) begin
      fwd_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter    <= '0;
      residue         <= '0;
      note_pointer    <= '0;
      steps_remaining <= '0;
      player_active   <= 1'b0;
      gate_enabled    <= 1'b0;
      current_divisor <= '0;
      fwd_valid       <= 1'b0;
    end else begin
      tick_counter    <= tick_counter_next;
      residue         <= residue_next;
      note_pointer    <= note_pointer_next;
      steps_remaining <= steps_remaining_next;
      player_active   <= player_active_next;
      gate_enabled    <= gate_enabled_next;
      current_divisor <= current_divisor_next;
      fwd_valid       <= fwd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fwd_word <= fwd_word_next;
  end

  assign result.tick_count       = tick_counter_next;
  assign result.speaker_on       = gate_enabled_next;
  assign result.tone_divisor     = current_divisor_next;
  assign result.playing          = player_active_next;
  assign result.interrupt_action = action;

  assign status.gate   = gate_enabled;
  assign status.active = player_active;

endmodule

[sv/tdsq_out_buf.sv]
module tdsq_out_buf import tdsq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  result_t     push_data,
  output logic        push_ready,
  output logic        pop_valid,
  input  logic        pop_ready,
  output result_t     pop_data,
  output buf_status_t status
);

  logic    main_valid, skid_valid;
  result_t main_data, skid_data;
  logic    pop;

  assign push_ready = !skid_valid;
  assign pop        = main_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push && !main_valid) begin
      main_data <= push_data;
    end
    if (push && main_valid && !pop) begin
      skid_data <= push_data;
    end
  end

  assign pop_valid = main_valid;
  assign pop_data  = main_data;

  assign status.main_valid = main_valid;
  assign status.skid_valid = skid_valid;

endmodule

[sv/tick_driven_tone_sequencer_unit.sv]
// Channel   Dir  Width  Content
// s_*       in   40+2   tick / note write / start item
// m_*       out  56+2   tick count, speaker state, divisor, playing, action
// cfg_*     in   16     stop marker
//
// One item per cycle while the output buffer has room; each transferred item yields one registered result.
// The note under the pointer is prefetched from the note RAM (registered read)
// whenever the pointer moves; writes to that entry are forwarded.
// Two-entry output buffer: input stalls only once two results wait downstream.
// Reset: synchronous, active high; counters, player and buffer cleared, note
// RAM keeps its contents. Config is always ready.
module tick_driven_tone_sequencer_unit import tdsq_pkg::*; #(
  parameter int NOTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // note_address[7:0], note_duration[23:8], note_divisor[39:24]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // tick_count[31:0], speaker_on[32], tone_divisor[48:33],
                                 // playing[49], zero fill[55:50]
  output logic [1:0]  m_tuser,   // interrupt_action[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // stop_marker[15:0]
);

  localparam int AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;

  logic           accept;
  logic [15:0]    stop_marker;
  logic           wr_en, rd_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  note_t          wr_data, rd_data;
  result_t        result, out_res;
  player_status_t pl_status;
  buf_status_t    bf_status;

  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_marker <= STOP_MARKER_RESET;
    end else if (cfg_valid) begin
      stop_marker <= cfg_data;
    end
  end

  tdsq_note_mem #(.DEPTH(NOTE_DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tdsq_player #(.DEPTH(NOTE_DEPTH), .AW(AW)) u_player (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .op            (s_tuser),
    .note_address  (s_tdata[7:0]),
    .note_duration (s_tdata[23:8]),
    .note_divisor  (s_tdata[39:24]),
    .stop_marker   (stop_marker),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .result        (result),
    .status        (pl_status)
  );

  tdsq_out_buf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (result),
    .push_ready (s_tready),
    .pop_valid  (m_tvalid),
    .pop_ready  (m_tready),
    .pop_data   (out_res),
    .status     (bf_status)
  );

  assign m_tdata = {6'd0, out_res.playing, out_res.tone_divisor, out_res.speaker_on,
                    out_res.tick_count};
  assign m_tuser = out_res.interrupt_action;

`ifndef SYNTH
  a_gate_needs_play: assert property (@(posedge clk) disable iff (rst)
    pl_status.gate |-> pl_status.active)
    else $error("speaker gate on while not playing");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    bf_status.skid_valid |-> bf_status.main_valid)
    else $error("skid entry held without main entry");

  a_tick_action: assert property (@(posedge clk) disable iff (rst)
    accept |-> ((s_tuser == OP_TICK) == (result.interrupt_action != ACT_NONE)))
    else $error("interrupt action does not match item kind");
`endif

endmodule
